>>> hw/rtl/mtfs_pkg.sv
`default_nettype none

package mtfs_pkg;

    localparam int WORD_W  = 32;
    localparam int SLOT_W  = 6;
    localparam int POS_W   = 6;
    localparam int COMP_W  = 7;
    localparam int CFG_W   = 7;

    localparam logic FUNC_LOAD   = 1'b0;
    localparam logic FUNC_SEARCH = 1'b1;

    typedef logic signed [WORD_W-1:0] t_word;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_RESTORE,
        S_DONE
    } t_state;

    typedef struct packed {
        logic              shift;
        logic              load;
        logic [SLOT_W-1:0] slot;
        t_word             data;
        t_word             tail;
    } t_cell_ctl;

endpackage

`default_nettype wire

>>> hw/rtl/mtfs_cell.sv
`default_nettype none

module mtfs_cell #(
    parameter int CELL_IDX = 0,
    parameter int CNT_W    = 7
) (
    input  wire                logic        i_clk,
    input  wire                mtfs_pkg::t_cell_ctl i_ctl,
    input  wire                logic [CNT_W-1:0] i_cnt,
    input  wire                mtfs_pkg::t_word i_next,
    output                     mtfs_pkg::t_word o_entry
);
    import mtfs_pkg::*;

    localparam bit LOADABLE = (CELL_IDX < (2 ** SLOT_W));

    t_word r_entry;
    logic  w_in_use;
    logic  w_last;
    logic  w_load_hit;

    assign w_in_use   = (CNT_W'(CELL_IDX) < i_cnt);
    assign w_last     = (CNT_W'(CELL_IDX + 1) == i_cnt);
    assign w_load_hit = LOADABLE && (i_ctl.slot == SLOT_W'(CELL_IDX));

    // load a slot, or advance the ring toward the head
    always_ff @(posedge i_clk) begin
        if (i_ctl.load && w_load_hit) begin
            r_entry <= i_ctl.data;
        end else if (i_ctl.shift && w_in_use) begin
            r_entry <= w_last ? i_ctl.tail : i_next;
        end
    end

    assign o_entry = r_entry;

endmodule

`default_nettype wire

>>> hw/rtl/move_to_front_search_table.sv
// Move-to-front search table.
// Input channel (i_in_valid / o_in_stall) carries one beat per item: i_func
// selects a load (i_slot, i_entry_value) or a search (i_search_key). A load
// is written in the cycle it is accepted and returns no beat. A search
// returns one beat on the output channel (o_out_valid / i_out_stall):
// o_found, o_old_position, o_comparisons.
// The in-use count is written through i_cfg_we / i_cfg_data and is clamped
// to TABLE_DEPTH. The user must write it only while idle; the block itself
// does not enforce this.
// A search rotates the in-use cells one step a cycle past a single
// comparator at slot 0. With n the clamped in-use count, a search scans all
// n cells, then goes to S_DONE on a hit, or through S_RESTORE on a miss to
// undo the speculative shift; with n zero it goes straight to S_DONE. The
// next item is taken once the result is loaded into the output register.
// The result sits in an output register; a new item is taken while it
// waits, and a search that finishes under output stall holds until the
// register frees up.
// Reset clears the count to zero and empties the output register; table
// contents are undefined until loaded.
`default_nettype none

module move_to_front_search_table #(
    parameter int TABLE_DEPTH = 64
) (
    input  wire  logic                           i_clk,
    input  wire  logic                           i_rst_n,
    input  wire  logic                           i_in_valid,
    output       logic                           o_in_stall,
    input  wire  logic                           i_func,
    input  wire  logic [mtfs_pkg::SLOT_W-1:0]    i_slot,
    input  wire  logic signed [mtfs_pkg::WORD_W-1:0] i_entry_value,
    input  wire  logic signed [mtfs_pkg::WORD_W-1:0] i_search_key,
    output       logic                           o_out_valid,
    input  wire  logic                           i_out_stall,
    output       logic                           o_found,
    output       logic [mtfs_pkg::POS_W-1:0]     o_old_position,
    output       logic [mtfs_pkg::COMP_W-1:0]    o_comparisons,
    input  wire  logic                           i_cfg_we,
    input  wire  logic [mtfs_pkg::CFG_W-1:0]     i_cfg_data
);
    import mtfs_pkg::*;

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam logic [CMP_W-1:0] DEPTH_EXT = CMP_W'(TABLE_DEPTH);

    t_state             r_state;
    t_state             n_state;
    logic [CFG_W-1:0]   r_cfg_cnt;
    logic [CNT_W-1:0]   r_cnt;
    logic [CNT_W-1:0]   r_step;
    logic [CNT_W-1:0]   r_pos;
    logic               r_hit;
    t_word              r_key;
    t_word              r_prev;
    logic               r_o_valid;
    logic               r_o_found;
    logic [POS_W-1:0]   r_o_pos;
    logic [COMP_W-1:0]  r_o_comp;

    t_word              w_entry [TABLE_DEPTH];
    t_cell_ctl          w_ctl;
    logic [CMP_W-1:0]   w_cfg_ext;
    logic [CNT_W-1:0]   w_cnt;
    logic               w_in_acc;
    logic               w_hit_now;
    logic               w_last_step;
    logic               w_out_free;
    logic               w_shift;
    logic               w_out_load;
    t_word              w_tail;

    assign w_cfg_ext   = CMP_W'(r_cfg_cnt);
    assign w_cnt       = (w_cfg_ext > DEPTH_EXT) ? CNT_W'(DEPTH_EXT) : CNT_W'(w_cfg_ext);
    assign o_in_stall  = (r_state != S_IDLE);
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign w_hit_now   = (r_state == S_SCAN) && !r_hit && (w_entry[0] == r_key);
    assign w_last_step = (r_step == CNT_W'(r_cnt - 1'b1));
    assign w_out_free  = !r_o_valid || !i_out_stall;

    assign w_ctl.shift = w_shift;
    assign w_ctl.load  = w_in_acc && (i_func == FUNC_LOAD);
    assign w_ctl.slot  = i_slot;
    assign w_ctl.data  = i_entry_value;
    assign w_ctl.tail  = w_tail;

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        t_word w_next;
        if (g == TABLE_DEPTH - 1) begin : g_end
            assign w_next = w_tail;
        end else begin : g_mid
            assign w_next = w_entry[g + 1];
        end
        mtfs_cell #(
            .CELL_IDX (g),
            .CNT_W    (CNT_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_cnt   (r_cnt),
            .i_next  (w_next),
            .o_entry (w_entry[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        w_shift    = 1'b0;
        w_tail     = r_key;
        w_out_load = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc && (i_func == FUNC_SEARCH)) begin
                    n_state = (w_cnt == '0) ? S_DONE : S_SCAN;
                end
            end
            S_SCAN: begin
                w_shift = 1'b1;
                // feed the key first, then the delayed head until the match drops out
                if (r_step != '0) begin
                    w_tail = r_hit ? w_entry[0] : r_prev;
                end
                if (w_last_step) begin
                    n_state = (r_hit || w_hit_now) ? S_DONE : S_RESTORE;
                end
            end
            S_RESTORE: begin
                w_shift = 1'b1;
                w_tail  = r_prev;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (w_out_free) begin
                    w_out_load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_cnt <= '0;
        end else if (i_cfg_we) begin
            r_cfg_cnt <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit  <= 1'b0;
            r_step <= '0;
        end else if (w_in_acc && (i_func == FUNC_SEARCH)) begin
            r_hit  <= 1'b0;
            r_step <= '0;
        end else if (r_state == S_SCAN) begin
            r_step <= r_step + 1'b1;
            if (w_hit_now) begin
                r_hit <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc && (i_func == FUNC_SEARCH)) begin
            r_key <= i_search_key;
            r_cnt <= w_cnt;
            r_pos <= '0;
        end else if (r_state == S_SCAN) begin
            r_prev <= w_entry[0];
            if (w_hit_now) begin
                r_pos <= r_step;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_out_load) begin
            r_o_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_o_found <= r_hit;
            r_o_pos   <= POS_W'(r_pos);
            r_o_comp  <= r_hit ? (COMP_W'(r_pos) + COMP_W'(1)) : COMP_W'(r_cnt);
        end
    end

    assign o_out_valid    = r_o_valid;
    assign o_found        = r_o_found;
    assign o_old_position = r_o_pos;
    assign o_comparisons  = r_o_comp;

endmodule

`default_nettype wire

>>> hw/rtl/mtfs_checker.sv
`default_nettype none

module mtfs_checker (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               o_out_valid,
    input  wire logic                               i_out_stall,
    input  wire logic                               o_found,
    input  wire logic [mtfs_pkg::POS_W-1:0]         o_old_position,
    input  wire logic [mtfs_pkg::COMP_W-1:0]        o_comparisons
);
    import mtfs_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("output beat dropped under stall");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            $stable({o_found, o_old_position, o_comparisons}))
        else $error("output beat changed under stall");

    a_miss_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_found) |-> (o_old_position == '0))
        else $error("miss reports a nonzero position");

    a_hit_comp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_found) |->
            (o_comparisons == (COMP_W'(o_old_position) + COMP_W'(1))))
        else $error("hit comparison count does not match position");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output beat present after reset");

endmodule

bind move_to_front_search_table mtfs_checker u_mtfs_checker (.*);

`default_nettype wire

>>> sim/tb.sv
`timescale 1ns / 100ps

module tb;

    import mtfs_pkg::*;

    localparam int DEPTH          = 64;
    localparam int SETTLE_CYCLES  = 80;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int PHASE_ITEMS    = 110;
    localparam int REPORT_LIMIT   = 10;

    typedef struct packed {
        logic              found;
        logic [POS_W-1:0]  old_pos;
        logic [COMP_W-1:0] comps;
    } t_search_result;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic                  i_func;
    logic [SLOT_W-1:0]     i_slot;
    t_word                 i_entry_value;
    t_word                 i_search_key;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic                  o_found;
    logic [POS_W-1:0]      o_old_position;
    logic [COMP_W-1:0]     o_comparisons;
    logic                  i_cfg_we;
    logic [CFG_W-1:0]      i_cfg_data;

    t_word                 mtf_table [DEPTH];
    bit                    slot_loaded [DEPTH];
    int unsigned           scan_len;
    t_search_result        pending_results [$];
    int unsigned           mismatches;
    int unsigned           idle_cycles;
    bit                    calm;

    move_to_front_search_table #(
        .TABLE_DEPTH(DEPTH)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_func         (i_func),
        .i_slot         (i_slot),
        .i_entry_value  (i_entry_value),
        .i_search_key   (i_search_key),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_found        (o_found),
        .o_old_position (o_old_position),
        .o_comparisons  (o_comparisons),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(99);
        if (calm || r < 55) return 0;
        if (r < 90) return $urandom_range(3, 1);
        if (r < 98) return $urandom_range(15, 4);
        return $urandom_range(80, 30);
    endfunction

    function automatic t_word rand_word();
        case ($urandom_range(7))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return '0;
            3: return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_word absent_key();
        t_word k;
        bit    present;
        do begin
            k = $urandom;
            present = 1'b0;
            for (int i = 0; i < DEPTH; i++)
                if (slot_loaded[i] && mtf_table[i] == k) present = 1'b1;
        end while (present);
        return k;
    endfunction

    function automatic void load_entry(input logic [SLOT_W-1:0] slot, input t_word value);
        mtf_table[slot]   = value;
        slot_loaded[slot] = 1'b1;
    endfunction

    function automatic void search_entry(input t_word key);
        t_search_result res;
        t_word          hit;
        int             pos;
        res.found   = 1'b0;
        res.old_pos = '0;
        res.comps   = scan_len[COMP_W-1:0];
        pos = -1;
        for (int i = 0; i < scan_len; i++)
            if (pos < 0 && mtf_table[i] == key) pos = i;
        if (pos >= 0) begin
            hit = mtf_table[pos];
            for (int i = pos; i > 0; i--) mtf_table[i] = mtf_table[i-1];
            mtf_table[0] = hit;
            res.found   = 1'b1;
            res.old_pos = pos[POS_W-1:0];
            res.comps   = COMP_W'(pos + 1);
        end
        pending_results.push_back(res);
    endfunction

    task automatic send_item(input logic func, input logic [SLOT_W-1:0] slot,
                             input t_word value, input t_word key);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_func        <= func;
        i_slot        <= slot;
        i_entry_value <= value;
        i_search_key  <= key;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        if (func == FUNC_LOAD) load_entry(slot, value);
        else search_entry(key);
    endtask

    task automatic send_load(input int slot, input t_word value);
        send_item(FUNC_LOAD, slot[SLOT_W-1:0], value, $urandom);
    endtask

    task automatic send_search(input t_word key);
        send_item(FUNC_SEARCH, SLOT_W'($urandom), $urandom, key);
    endtask

    task automatic settle(input bit tail);
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
        if (tail) repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_count(input logic [CFG_W-1:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        scan_len = (value > DEPTH) ? DEPTH : value;
    endtask

    task automatic fill_in_use();
        for (int i = 0; i < scan_len; i++)
            if (!slot_loaded[i]) send_load(i, rand_word());
    endtask

    task automatic test_reset_count();
        send_search(rand_word());
        settle(1'b1);
    endtask

    task automatic test_hit_and_rotate();
        write_count(CFG_W'(4));
        send_load(0, 32'sh8000_0000);
        send_load(1, 32'sh7fff_ffff);
        send_load(2, '0);
        send_load(3, '1);
        send_search('1);
        send_search(32'sh8000_0000);
        send_search(absent_key());
        send_search('0);
        send_search('0);
        send_load(3, 32'sh8000_0000);
        send_search(32'sh8000_0000);
        send_search(mtf_table[3]);
        settle(1'b1);
    endtask

    task automatic test_count_limits();
        write_count(CFG_W'(1));
        send_search(mtf_table[0]);
        send_search(mtf_table[1]);
        for (int i = 0; i < DEPTH; i++)
            if (!slot_loaded[i]) send_load(i, $urandom);
        settle(1'b1);
        write_count('1);
        send_search(mtf_table[DEPTH-1]);
        send_search(absent_key());
        settle(1'b1);
        write_count(CFG_W'(DEPTH));
        send_search(mtf_table[DEPTH-1]);
        send_search(absent_key());
        send_search(mtf_table[DEPTH/2]);
        settle(1'b1);
    endtask

    task automatic test_random_traffic();
        logic [CFG_W-1:0] counts [7];
        int unsigned      r;
        int unsigned      idx;
        t_word            key;
        t_word            value;
        counts = '{CFG_W'(0), CFG_W'(2), CFG_W'($urandom_range(63, 3)), CFG_W'(1),
                   CFG_W'($urandom_range(127, 65)), CFG_W'(DEPTH),
                   CFG_W'($urandom_range(40, 5))};
        for (int phase = 0; phase < 7; phase++) begin
            write_count(counts[phase]);
            fill_in_use();
            calm = (phase == 3);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (k == PHASE_ITEMS / 2) settle(1'b0);
                r = $urandom_range(99);
                if (r < 70) begin
                    r = $urandom_range(99);
                    idx = $urandom_range(DEPTH-1);
                    if (scan_len != 0 && r < 65)
                        key = mtf_table[$urandom_range(scan_len-1)];
                    else if (r < 80 && slot_loaded[idx])
                        key = mtf_table[idx];
                    else
                        key = rand_word();
                    send_search(key);
                end else begin
                    idx = $urandom_range(DEPTH-1);
                    if (scan_len != 0 && $urandom_range(99) < 30)
                        value = mtf_table[$urandom_range(scan_len-1)];
                    else
                        value = rand_word();
                    send_load(idx, value);
                end
            end
            calm = 1'b0;
            settle(1'b1);
        end
    endtask

    initial begin
        i_out_stall <= 1'b0;
        forever begin
            int unsigned stall_len;
            @(posedge i_clk);
            stall_len = pick_gap();
            if (stall_len != 0) begin
                i_out_stall <= 1'b1;
                repeat (stall_len) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin : check_results
        t_search_result want;
        t_search_result got;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = {o_found, o_old_position, o_comparisons};
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected result beat: found=%b pos=%0d comps=%0d",
                             got.found, got.old_pos, got.comps);
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display({"mismatch: exp found=%b pos=%0d comps=%0d,",
                                  " got found=%b pos=%0d comps=%0d"},
                                 want.found, want.old_pos, want.comps,
                                 got.found, got.old_pos, got.comps);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            i_cfg_we) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        i_rst_n       <= 1'b0;
        i_in_valid    <= 1'b0;
        i_func        <= FUNC_LOAD;
        i_slot        <= '0;
        i_entry_value <= '0;
        i_search_key  <= '0;
        i_cfg_we      <= 1'b0;
        i_cfg_data    <= '0;
        idle_cycles   = 0;
        mismatches    = 0;
        scan_len      = 0;
        calm          = 1'b0;
        for (int i = 0; i < DEPTH; i++) begin
            mtf_table[i]   = '0;
            slot_loaded[i] = 1'b0;
        end
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_count();
        test_hit_and_rotate();
        test_count_limits();
        test_random_traffic();
        settle(1'b1);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/mtfs_pkg.sv
hw/rtl/mtfs_cell.sv
hw/rtl/move_to_front_search_table.sv
hw/rtl/mtfs_checker.sv
sim/tb.sv
